@@ rtl/rbd_pkg.sv @@
`timescale 1ns / 1ps
// rbd_pkg: widths, item structs and cell struct shared by the rounded box distance block
package rbd_pkg;

   // coordinate format: signed fixed point, fraction position does not matter to the datapath
   localparam int COORD_W = 24;
   localparam int HALF_W  = COORD_W - 1;
   // squared length of three clamped axes always fits in twice the coordinate width
   localparam int SUM_W   = 2 * COORD_W;
   // root of the squared length, one bit per cell
   localparam int ROOT_W  = COORD_W;
   localparam int STEPS   = COORD_W;
   // partial remainder with room for the two incoming bits
   localparam int REM_W   = COORD_W + 3;

   // largest positive distance
   localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic [HALF_W-1:0]         half_x;
      logic [HALF_W-1:0]         half_y;
      logic [HALF_W-1:0]         half_z;
      logic [HALF_W-1:0]         round_radius;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] distance;
      logic                      saturated;
   } rsp_type;

   // what one square root cell hands to the next
   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  radicand;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [HALF_W-1:0] radius;
   } cell_type;

endpackage

@@ rtl/rbd_front.sv @@
`timescale 1ns / 1ps
// rbd_front: per-axis excess, squares and squared length ahead of the root chain
module rbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  rbd_pkg::req_type in_data,
   output rbd_pkg::cell_type out_cell
);

   logic [rbd_pkg::COORD_W-1:0] mag_x, mag_y, mag_z;
   logic [rbd_pkg::COORD_W:0]   diff_x, diff_y, diff_z;
   logic [rbd_pkg::COORD_W-1:0] ex_x_in, ex_y_in, ex_z_in;
   logic [rbd_pkg::COORD_W-1:0] ex_x_ff, ex_y_ff, ex_z_ff;
   logic [rbd_pkg::HALF_W-1:0]  rad_a_ff, rad_b_ff, rad_c_ff;
   logic                        val_a_ff, val_b_ff, val_c_ff;
   logic [rbd_pkg::SUM_W-1:0]   sq_x_in, sq_y_in, sq_z_in;
   logic [rbd_pkg::SUM_W-1:0]   sq_x_ff, sq_y_ff, sq_z_ff;
   logic [rbd_pkg::SUM_W-1:0]   sum_in, sum_ff;

   // magnitude; the most negative value maps to its exact unsigned magnitude
   always_comb begin
      mag_x = in_data.point_x[rbd_pkg::COORD_W-1] ? (~in_data.point_x + 1'b1) : in_data.point_x;
      mag_y = in_data.point_y[rbd_pkg::COORD_W-1] ? (~in_data.point_y + 1'b1) : in_data.point_y;
      mag_z = in_data.point_z[rbd_pkg::COORD_W-1] ? (~in_data.point_z + 1'b1) : in_data.point_z;
   end

   // subtract half extent, clamp at zero
   always_comb begin
      diff_x  = {1'b0, mag_x} - {2'b00, in_data.half_x};
      diff_y  = {1'b0, mag_y} - {2'b00, in_data.half_y};
      diff_z  = {1'b0, mag_z} - {2'b00, in_data.half_z};
      ex_x_in = diff_x[rbd_pkg::COORD_W] ? '0 : diff_x[rbd_pkg::COORD_W-1:0];
      ex_y_in = diff_y[rbd_pkg::COORD_W] ? '0 : diff_y[rbd_pkg::COORD_W-1:0];
      ex_z_in = diff_z[rbd_pkg::COORD_W] ? '0 : diff_z[rbd_pkg::COORD_W-1:0];
   end

   // one multiplier per axis
   always_comb begin
      sq_x_in = ex_x_ff * ex_x_ff;
      sq_y_in = ex_y_ff * ex_y_ff;
      sq_z_in = ex_z_ff * ex_z_ff;
      sum_in  = sq_x_ff + sq_y_ff + sq_z_ff;
   end

   // item valid through the three front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         val_a_ff <= 1'b0;
         val_b_ff <= 1'b0;
         val_c_ff <= 1'b0;
      end else if (enable) begin
         val_a_ff <= in_valid;
         val_b_ff <= val_a_ff;
         val_c_ff <= val_b_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (enable) begin
         ex_x_ff  <= ex_x_in;
         ex_y_ff  <= ex_y_in;
         ex_z_ff  <= ex_z_in;
         rad_a_ff <= in_data.round_radius;
         sq_x_ff  <= sq_x_in;
         sq_y_ff  <= sq_y_in;
         sq_z_ff  <= sq_z_in;
         rad_b_ff <= rad_a_ff;
         sum_ff   <= sum_in;
         rad_c_ff <= rad_b_ff;
      end
   end

   // seed of the root chain
   always_comb begin
      out_cell.valid    = val_c_ff;
      out_cell.radicand = sum_ff;
      out_cell.rem      = '0;
      out_cell.root     = '0;
      out_cell.radius   = rad_c_ff;
   end

endmodule

@@ rtl/rbd_sqrt_cell.sv @@
`timescale 1ns / 1ps
// rbd_sqrt_cell: one digit-by-digit square root step, takes two radicand bits, yields one root bit
module rbd_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  rbd_pkg::cell_type in_cell,
   output rbd_pkg::cell_type out_cell
);

   logic [rbd_pkg::REM_W-1:0] shifted;
   logic [rbd_pkg::REM_W-1:0] trial;
   logic                      fits;
   rbd_pkg::cell_type         cell_in, cell_ff;

   // bring down the next two radicand bits and try root*4+1
   always_comb begin
      shifted = {in_cell.rem[rbd_pkg::REM_W-3:0],
                 in_cell.radicand[rbd_pkg::SUM_W-1:rbd_pkg::SUM_W-2]};
      trial   = rbd_pkg::REM_W'({in_cell.root, 2'b01});
      fits    = (shifted >= trial);
      cell_in.valid    = in_cell.valid;
      cell_in.radicand = {in_cell.radicand[rbd_pkg::SUM_W-3:0], 2'b00};
      cell_in.rem      = fits ? (shifted - trial) : shifted;
      cell_in.root     = {in_cell.root[rbd_pkg::ROOT_W-2:0], fits};
      cell_in.radius   = in_cell.radius;
   end

   // hand the partial result to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (enable) begin
         cell_ff.radicand <= cell_in.radicand;
         cell_ff.rem      <= cell_in.rem;
         cell_ff.root     <= cell_in.root;
         cell_ff.radius   <= cell_in.radius;
      end
   end

   assign out_cell = cell_ff;

endmodule

@@ rtl/rbd_back.sv @@
`timescale 1ns / 1ps
// rbd_back: round the root, subtract the radius and saturate into the result register
module rbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  rbd_pkg::cell_type in_cell,
   output logic              out_valid,
   output rbd_pkg::rsp_type  out_data
);

   logic [rbd_pkg::ROOT_W:0]    rounded;
   logic [rbd_pkg::COORD_W+1:0] diff;
   logic                        over;
   rbd_pkg::rsp_type            rsp_in, rsp_ff;
   logic                        valid_ff;

   // round to nearest: bump when the remainder exceeds the root
   always_comb begin
      rounded = {1'b0, in_cell.root} +
                (rbd_pkg::ROOT_W + 1)'(rbd_pkg::REM_W'(in_cell.root) < in_cell.rem);
      diff    = (rbd_pkg::COORD_W + 2)'(rounded) - (rbd_pkg::COORD_W + 2)'(in_cell.radius);
      over    = !diff[rbd_pkg::COORD_W+1] &&
                (diff[rbd_pkg::COORD_W:0] > (rbd_pkg::COORD_W + 1)'(rbd_pkg::DIST_MAX));
      rsp_in.distance  = over ? rbd_pkg::DIST_MAX : diff[rbd_pkg::COORD_W-1:0];
      rsp_in.saturated = over;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

@@ rtl/rounded_box_distance.sv @@
`timescale 1ns / 1ps
// Rounded box distance: from item accept to result valid an item passes three front stages,
// one root cell per root bit and one output stage.
// Throughput is one item per cycle; the whole pipeline advances together and holds while a
// result waits under rsp_stall, and a one-item input skid register keeps req_stall registered.
// Synchronous active-high reset clears all valid flags and the skid; payload registers are not reset.
module rounded_box_distance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbd_pkg::rsp_type rsp_data
);

   logic              pipe_en;
   logic              accept;
   logic              skid_full_ff, skid_full_in;
   rbd_pkg::req_type  skid_ff;
   logic              src_valid;
   rbd_pkg::req_type  src_data;
   rbd_pkg::cell_type chain [0:rbd_pkg::STEPS];

   // pipeline moves unless a finished item is held at the output
   assign pipe_en   = !rsp_valid || !rsp_stall;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid && !skid_full_ff;

   // skid register feeds the pipeline first
   always_comb begin
      src_valid = skid_full_ff || accept;
      src_data  = skid_full_ff ? skid_ff : req_data;
   end

   always_comb begin
      if (pipe_en) begin
         skid_full_in = 1'b0;
      end else begin
         skid_full_in = skid_full_ff || accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && accept) begin
         skid_ff <= req_data;
      end
   end

   // excess, squares and sum
   rbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (pipe_en),
      .in_valid (src_valid),
      .in_data  (src_data),
      .out_cell (chain[0])
   );

   // row of square root cells
   for (genvar i = 0; i < rbd_pkg::STEPS; i++) begin : g_cell
      rbd_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (pipe_en),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   // rounding, radius and saturation
   rbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_cell   (chain[rbd_pkg::STEPS]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

@@ bench/rounded_box_distance_tb.sv @@
`timescale 1ns / 1ps
// rounded_box_distance_tb: self-checking bench for the rounded box distance pipeline
module rounded_box_distance_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = rbd_pkg::COORD_W + 12;
   localparam int NROWS = 19;

   typedef logic signed [rbd_pkg::COORD_W-1:0] coord_type;
   typedef logic [rbd_pkg::HALF_W-1:0]         half_type;

   // one item waiting to be sent, with an optional hand-typed answer
   typedef struct {
      rbd_pkg::req_type q;
      bit               known;
      rbd_pkg::rsp_type want;
   } query_type;

   // directed probe: point, half extents, radius, and the answer when obvious
   typedef struct {
      coord_type px, py, pz;
      half_type  hx, hy, hz, rad;
      bit        known;
      coord_type want_dist;
      bit        sat;
   } probe_type;

   probe_type probe_table [NROWS] = '{
      // origin, empty box
      '{24'h0, 24'h0, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b1, 24'h0, 1'b0},
      // inside the box gives minus the radius
      '{24'h010000, 24'hFF0000, 24'h008000, 23'h020000, 23'h020000, 23'h020000,
        23'h008000, 1'b1, 24'hFF8000, 1'b0},
      // smallest possible result
      '{24'h0, 24'h0, 24'h0, 23'h0, 23'h0, 23'h0, 23'h7FFFFF, 1'b1, 24'h800001, 1'b0},
      // most negative coordinate alone overflows
      '{24'h800000, 24'h0, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b1, 24'h7FFFFF, 1'b1},
      // largest positive coordinate just fits
      '{24'h7FFFFF, 24'h0, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b1, 24'h7FFFFF, 1'b0},
      // most negative coordinate less a radius of one step just fits
      '{24'h800000, 24'h0, 24'h0, 23'h0, 23'h0, 23'h0, 23'h1, 1'b1, 24'h7FFFFF, 1'b0},
      // extreme z against the largest radius
      '{24'h0, 24'h0, 24'h800000, 23'h0, 23'h0, 23'h0, 23'h7FFFFF, 1'b1, 24'h000001, 1'b0},
      // far corner, largest radius
      '{24'h800000, 24'h800000, 24'h800000, 23'h0, 23'h0, 23'h0, 23'h7FFFFF,
        1'b0, 24'h0, 1'b0},
      // far corner, no radius
      '{24'h800000, 24'h800000, 24'h800000, 23'h0, 23'h0, 23'h0, 23'h0,
        1'b1, 24'h7FFFFF, 1'b1},
      // largest box swallows the largest point
      '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
        23'h0, 1'b1, 24'h0, 1'b0},
      // largest box, most negative point sticks out one step per axis
      '{24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
        23'h0, 1'b0, 24'h0, 1'b0},
      // exact root
      '{24'h000003, 24'hFFFFFC, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b1, 24'h000005, 1'b0},
      // roots that round down and up
      '{24'h000001, 24'h000001, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b0, 24'h0, 1'b0},
      '{24'h000002, 24'h000001, 24'hFFFFFF, 23'h0, 23'h0, 23'h0, 23'h0, 1'b0, 24'h0, 1'b0},
      '{24'h000002, 24'h000002, 24'h000002, 23'h0, 23'h0, 23'h0, 23'h0, 1'b0, 24'h0, 1'b0},
      '{24'h000003, 24'hFFFFFE, 24'h0, 23'h0, 23'h0, 23'h0, 23'h0, 1'b0, 24'h0, 1'b0},
      // fractional point near a unit box
      '{24'h018000, 24'hFDC000, 24'h00C000, 23'h010000, 23'h010000, 23'h010000,
        23'h004000, 1'b0, 24'h0, 1'b0},
      // mixed bit patterns
      '{24'h555555, 24'hAAAAAA, 24'h333333, 23'h2AAAAA, 23'h555555, 23'h4CCCCC,
        23'h0F0F0F, 1'b0, 24'h0, 1'b0},
      // one step outside a face
      '{24'h0, 24'h020001, 24'h0, 23'h010000, 23'h020000, 23'h010000, 23'h0,
        1'b1, 24'h000001, 1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rbd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rbd_pkg::rsp_type rsp_data;

   query_type        query_q [$];
   rbd_pkg::rsp_type due_q [$];
   query_type        on_air;
   rbd_pkg::rsp_type due;

   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_sender = 1'b0;
   int hold_req = 0;
   int hold_left = 0;

   int cycle_count = 0;
   int mismatches = 0;
   int items_taken = 0;
   int results_seen = 0;
   int sat_seen = 0;
   int negative_seen = 0;
   int input_stall_cycles = 0;

   rounded_box_distance dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // how far one coordinate pokes out past the half extent
   function automatic longint axis_overhang(coord_type p, half_type h);
      longint mag;
      longint lim;
      mag = longint'(p);
      lim = longint'(h);
      if (mag < 0) mag = -mag;
      return (mag > lim) ? mag - lim : 0;
   endfunction

   // square root rounded to the nearest integer
   function automatic longint nearest_root(longint n);
      longint root;
      longint trial;
      root = 0;
      for (int b = 25; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      // above root^2 + root means nearer to root + 1
      if (n - root * root > root) root++;
      return root;
   endfunction

   // expected distance and overflow flag for one query
   function automatic rbd_pkg::rsp_type box_distance(rbd_pkg::req_type q);
      longint ex, ey, ez, len, rad, d, top;
      rbd_pkg::rsp_type r;
      ex = axis_overhang(q.point_x, q.half_x);
      ey = axis_overhang(q.point_y, q.half_y);
      ez = axis_overhang(q.point_z, q.half_z);
      len = nearest_root(ex * ex + ey * ey + ez * ez);
      rad = longint'(q.round_radius);
      top = longint'(rbd_pkg::DIST_MAX);
      d = len - rad;
      r.saturated = (d > top);
      r.distance = r.saturated ? rbd_pkg::DIST_MAX : d[rbd_pkg::COORD_W-1:0];
      return r;
   endfunction

   // coordinate close to the face of a box with half extent h
   function automatic coord_type near_face(int h);
      int off, mag;
      off = $urandom_range(1 << $urandom_range(20));
      mag = $urandom_range(1) ? h + off : h - off;
      if (mag < 0) mag = -mag;
      if (mag > 8388608) mag = 8388608;
      return coord_type'($urandom_range(1) ? -mag : mag);
   endfunction

   function automatic coord_type inside_coord(int h);
      int mag;
      mag = $urandom_range(h);
      return coord_type'($urandom_range(1) ? -mag : mag);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h0;
         3: return 24'h000001;
         4: return 24'hFFFFFF;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic half_type edge_size();
      case ($urandom_range(3))
         0: return 23'h0;
         1: return 23'h7FFFFF;
         2: return 23'h1;
         default: return half_type'($urandom);
      endcase
   endfunction

   // random query, half of the time near realistic box surfaces
   function automatic rbd_pkg::req_type random_query();
      rbd_pkg::req_type q;
      q = '0;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            q.half_x = half_type'($urandom_range(1 << $urandom_range(22, 4)));
            q.half_y = half_type'($urandom_range(1 << $urandom_range(22, 4)));
            q.half_z = half_type'($urandom_range(1 << $urandom_range(22, 4)));
            q.point_x = near_face(int'(q.half_x));
            q.point_y = near_face(int'(q.half_y));
            q.point_z = near_face(int'(q.half_z));
            q.round_radius = half_type'($urandom_range(1 << $urandom_range(20)));
         end
         5, 6: begin
            q = rbd_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom});
         end
         7: begin
            q.half_x = half_type'($urandom);
            q.half_y = half_type'($urandom);
            q.half_z = half_type'($urandom);
            q.point_x = inside_coord(int'(q.half_x));
            q.point_y = inside_coord(int'(q.half_y));
            q.point_z = inside_coord(int'(q.half_z));
            q.round_radius = half_type'($urandom);
         end
         8: begin
            q.point_x = edge_coord();
            q.point_y = edge_coord();
            q.point_z = edge_coord();
            q.half_x = edge_size();
            q.half_y = edge_size();
            q.half_z = edge_size();
            q.round_radius = edge_size();
         end
         default: begin
            // far points against tiny boxes, often past the format
            q.point_x = coord_type'($urandom);
            q.point_y = coord_type'($urandom);
            q.point_z = coord_type'($urandom);
            q.half_x = half_type'($urandom_range(255));
            q.half_y = half_type'($urandom_range(255));
            q.half_z = half_type'($urandom_range(255));
            q.round_radius = half_type'($urandom_range(255));
         end
      endcase
      return q;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic queue_random(int n);
      query_type e;
      repeat (n) begin
         e.q = random_query();
         e.known = 1'b0;
         e.want = '0;
         query_q.push_back(e);
      end
   endtask

   // wait until every queued item is sent and every result is back
   task automatic wait_idle();
      while (query_q.size() != 0 || req_valid || due_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(int idle, int stall, int n);
      send_idle_pct = idle;
      stall_pct = stall;
      queue_random(n);
      wait_idle();
   endtask

   // sender side and result scoring
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // score a result against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: distance %h saturated %b",
                                         rsp_data.distance, rsp_data.saturated));
            end else begin
               due = due_q.pop_front();
               if (rsp_data.distance !== due.distance)
                  report_mismatch($sformatf("distance expected %h got %h",
                                            due.distance, rsp_data.distance));
               if (rsp_data.saturated !== due.saturated)
                  report_mismatch($sformatf("saturated expected %b got %b (distance %h)",
                                            due.saturated, rsp_data.saturated, due.distance));
               if (due.saturated) sat_seen++;
               if (due.distance < 0) negative_seen++;
            end
         end
         // item taken: work out its answer
         if (req_valid && !req_stall) begin
            due_q.push_back(on_air.known ? on_air.want : box_distance(on_air.q));
            items_taken++;
         end
         if (req_valid && req_stall) input_stall_cycles++;
         // offer the next item or go idle
         if (!req_valid || !req_stall) begin
            if (query_q.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               on_air = query_q.pop_front();
               req_valid <= 1'b1;
               req_data <= on_air.q;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls, with long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rounded_box_distance_tb: done, errors");
         $finish;
      end
   end

   initial begin
      query_type e;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed probes
      foreach (probe_table[i]) begin
         e.q.point_x = probe_table[i].px;
         e.q.point_y = probe_table[i].py;
         e.q.point_z = probe_table[i].pz;
         e.q.half_x = probe_table[i].hx;
         e.q.half_y = probe_table[i].hy;
         e.q.half_z = probe_table[i].hz;
         e.q.round_radius = probe_table[i].rad;
         e.known = probe_table[i].known;
         e.want.distance = probe_table[i].want_dist;
         e.want.saturated = probe_table[i].sat;
         query_q.push_back(e);
      end
      wait_idle();

      // random traffic under different idle mixes
      run_phase(0, 0, 300);
      run_phase(71, 0, 300);
      run_phase(0, 71, 300);
      run_phase(23, 23, 300);

      // long receiver hold-off while the sender keeps pushing
      send_idle_pct = 0;
      stall_pct = 0;
      queue_random(300);
      hold_req = 400;
      do @(posedge clock); while (hold_req != 0 || hold_left != 0);
      // sender waits for the pipeline to empty, then resumes
      hold_sender = 1'b1;
      while (due_q.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      wait_idle();

      // let any stray result show up
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items (%0d directed), %0d results: %0d saturated, %0d negative",
               items_taken, NROWS, results_seen, sat_seen, negative_seen);
      $display("input held back on %0d cycles, %0d mismatches", input_stall_cycles,
               mismatches);
      if (mismatches == 0) begin
         $display("rounded_box_distance_tb: done, clean");
      end else begin
         $display("rounded_box_distance_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ rounded_box_distance.f @@
rtl/rbd_pkg.sv
rtl/rbd_front.sv
rtl/rbd_sqrt_cell.sv
rtl/rbd_back.sv
rtl/rounded_box_distance.sv
bench/rounded_box_distance_tb.sv
